// ===== rtl/core/ps2s1_pkg.sv =====
// ps2s1_pkg: shared types, keycode constants and lookup ROM contents for the
// PS/2 set-1 scan code decoder. No dependencies.

package ps2s1_pkg;

  // Raw byte codes seen on the wire
  localparam logic [7:0] SC_E0         = 8'hE0;
  localparam logic [7:0] SC_E1         = 8'hE1;
  localparam logic [7:0] SC_CTRL_BRK   = 8'h9D;
  localparam logic [7:0] SC_ALT_BRK    = 8'hB8;
  localparam logic [7:0] SC_RSHIFT_BRK = 8'hB6;
  localparam logic [7:0] SC_LSHIFT_BRK = 8'hAA;
  localparam logic [7:0] SC_PRTSC_A    = 8'h2A;
  localparam logic [7:0] SC_PRTSC_B    = 8'hB7;

  // Bytes swallowed after Print Screen and Pause lead-ins
  localparam logic [2:0] SKIP_PRTSC = 3'd2;
  localparam logic [2:0] SKIP_PAUSE = 3'd5;

  // Row/column keycodes of the modifier keys, plus the no-key code and the table limit
  localparam logic [7:0] KC_CAPS   = 8'h60;
  localparam logic [7:0] KC_LSHIFT = 8'h80;
  localparam logic [7:0] KC_RSHIFT = 8'h8B;
  localparam logic [7:0] KC_LCTRL  = 8'hA0;
  localparam logic [7:0] KC_RCTRL  = 8'hA4;
  localparam logic [7:0] KC_LALT   = 8'hA1;
  localparam logic [7:0] KC_RALT   = 8'hA3;
  localparam logic [7:0] KC_SCROLL = 8'h0E;
  localparam logic [7:0] KC_NUM    = 8'h31;
  localparam logic [7:0] KC_NONE   = 8'hFF;
  localparam logic [7:0] KC_LIMIT  = 8'd176;

  // Modifier bit positions
  localparam int unsigned MB_SHIFT  = 0;
  localparam int unsigned MB_ALT    = 1;
  localparam int unsigned MB_CTRL   = 2;
  localparam int unsigned MB_CAPS   = 3;
  localparam int unsigned MB_SCROLL = 4;
  localparam int unsigned MB_NUM    = 5;

  // Work handed from the byte front end to the modifier stage
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_KEY,
    CMD_CLR_SHIFT,
    CMD_CLR_ALT,
    CMD_CLR_CTRL
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } s1_t;

  // Keymap ROM: address bit 7 selects the E0 page, bits 6..0 the make code
  function automatic logic [7:0] key_map(input logic [7:0] addr);
    logic [7:0] k;
    k = KC_NONE;
    case (addr)
      8'h01: k = 8'h00; 8'h02: k = 8'h21; 8'h03: k = 8'h22; 8'h04: k = 8'h23;
      8'h05: k = 8'h24; 8'h06: k = 8'h25; 8'h07: k = 8'h26; 8'h08: k = 8'h27;
      8'h09: k = 8'h28; 8'h0A: k = 8'h29; 8'h0B: k = 8'h2A; 8'h0C: k = 8'h2B;
      8'h0D: k = 8'h2C; 8'h0E: k = 8'h2D; 8'h0F: k = 8'h40; 8'h10: k = 8'h41;
      8'h11: k = 8'h42; 8'h12: k = 8'h43; 8'h13: k = 8'h44; 8'h14: k = 8'h45;
      8'h15: k = 8'h46; 8'h16: k = 8'h47; 8'h17: k = 8'h48; 8'h18: k = 8'h49;
      8'h19: k = 8'h4A; 8'h1A: k = 8'h4B; 8'h1B: k = 8'h4C; 8'h1C: k = 8'h6C;
      8'h1D: k = 8'hA0; 8'h1E: k = 8'h61; 8'h1F: k = 8'h62; 8'h20: k = 8'h63;
      8'h21: k = 8'h64; 8'h22: k = 8'h65; 8'h23: k = 8'h66; 8'h24: k = 8'h67;
      8'h25: k = 8'h68; 8'h26: k = 8'h69; 8'h27: k = 8'h6A; 8'h28: k = 8'h6B;
      8'h29: k = 8'h20; 8'h2A: k = 8'h80; 8'h2B: k = 8'h4D; 8'h2C: k = 8'h81;
      8'h2D: k = 8'h82; 8'h2E: k = 8'h83; 8'h2F: k = 8'h84; 8'h30: k = 8'h85;
      8'h31: k = 8'h86; 8'h32: k = 8'h87; 8'h33: k = 8'h88; 8'h34: k = 8'h89;
      8'h35: k = 8'h8A; 8'h36: k = 8'h8B; 8'h37: k = 8'h33; 8'h38: k = 8'hA1;
      8'h39: k = 8'hA2; 8'h3A: k = 8'h60; 8'h3B: k = 8'h01; 8'h3C: k = 8'h02;
      8'h3D: k = 8'h03; 8'h3E: k = 8'h04; 8'h3F: k = 8'h05; 8'h40: k = 8'h06;
      8'h41: k = 8'h07; 8'h42: k = 8'h08; 8'h43: k = 8'h09; 8'h44: k = 8'h0A;
      8'h45: k = 8'h31; 8'h46: k = 8'h0E; 8'h47: k = 8'h51; 8'h48: k = 8'h52;
      8'h49: k = 8'h53; 8'h4A: k = 8'h34; 8'h4B: k = 8'h6D; 8'h4C: k = 8'h6E;
      8'h4D: k = 8'h6F; 8'h4E: k = 8'h54; 8'h4F: k = 8'h8D; 8'h50: k = 8'h8E;
      8'h51: k = 8'h8F; 8'h52: k = 8'hA8; 8'h53: k = 8'hA9; 8'h57: k = 8'h0B;
      8'h58: k = 8'h0C;
      // E0 page
      8'h9C: k = 8'h90; 8'h9D: k = 8'hA4; 8'hB5: k = 8'h32; 8'hB8: k = 8'hA3;
      8'hC7: k = 8'h2F; 8'hC8: k = 8'h8C; 8'hC9: k = 8'h30; 8'hCB: k = 8'hA5;
      8'hCD: k = 8'hA7; 8'hCF: k = 8'h4F; 8'hD0: k = 8'hA6; 8'hD1: k = 8'h50;
      8'hD2: k = 8'h2E; 8'hD3: k = 8'h4E;
      default: k = KC_NONE;
    endcase
    return k;
  endfunction

  // ASCII ROM indexed by shift and keycode; 0 where the key prints nothing
  function automatic logic [6:0] ascii_map(input logic sh, input logic [7:0] key);
    logic [6:0] c;
    c = 7'h00;
    case (key)
      8'h20: c = sh ? 7'h7E : 7'h60;
      8'h21: c = sh ? 7'h21 : 7'h31;
      8'h22: c = sh ? 7'h40 : 7'h32;
      8'h23: c = sh ? 7'h23 : 7'h33;
      8'h24: c = sh ? 7'h24 : 7'h34;
      8'h25: c = sh ? 7'h25 : 7'h35;
      8'h26: c = sh ? 7'h5E : 7'h36;
      8'h27: c = sh ? 7'h26 : 7'h37;
      8'h28: c = sh ? 7'h2A : 7'h38;
      8'h29: c = sh ? 7'h28 : 7'h39;
      8'h2A: c = sh ? 7'h29 : 7'h30;
      8'h2B: c = sh ? 7'h5F : 7'h2D;
      8'h2C: c = sh ? 7'h2B : 7'h3D;
      8'h2D: c = 7'h08;
      8'h32: c = 7'h2F;
      8'h33: c = 7'h2A;
      8'h34: c = 7'h2D;
      8'h41: c = sh ? 7'h51 : 7'h71;
      8'h42: c = sh ? 7'h57 : 7'h77;
      8'h43: c = sh ? 7'h45 : 7'h65;
      8'h44: c = sh ? 7'h52 : 7'h72;
      8'h45: c = sh ? 7'h54 : 7'h74;
      8'h46: c = sh ? 7'h59 : 7'h79;
      8'h47: c = sh ? 7'h55 : 7'h75;
      8'h48: c = sh ? 7'h49 : 7'h69;
      8'h49: c = sh ? 7'h4F : 7'h6F;
      8'h4A: c = sh ? 7'h50 : 7'h70;
      8'h4B: c = sh ? 7'h7B : 7'h5B;
      8'h4C: c = sh ? 7'h7D : 7'h5D;
      8'h4D: c = sh ? 7'h7C : 7'h5C;
      8'h51: c = 7'h37;
      8'h52: c = 7'h38;
      8'h53: c = 7'h39;
      8'h54: c = 7'h2B;
      8'h61: c = sh ? 7'h41 : 7'h61;
      8'h62: c = sh ? 7'h53 : 7'h73;
      8'h63: c = sh ? 7'h44 : 7'h64;
      8'h64: c = sh ? 7'h46 : 7'h66;
      8'h65: c = sh ? 7'h47 : 7'h67;
      8'h66: c = sh ? 7'h48 : 7'h68;
      8'h67: c = sh ? 7'h4A : 7'h6A;
      8'h68: c = sh ? 7'h4B : 7'h6B;
      8'h69: c = sh ? 7'h4C : 7'h6C;
      8'h6A: c = sh ? 7'h3A : 7'h3B;
      8'h6B: c = sh ? 7'h22 : 7'h27;
      8'h6C: c = 7'h0A;
      8'h6D: c = 7'h34;
      8'h6E: c = 7'h35;
      8'h6F: c = 7'h36;
      8'h81: c = sh ? 7'h5A : 7'h7A;
      8'h82: c = sh ? 7'h58 : 7'h78;
      8'h83: c = sh ? 7'h43 : 7'h63;
      8'h84: c = sh ? 7'h56 : 7'h76;
      8'h85: c = sh ? 7'h42 : 7'h62;
      8'h86: c = sh ? 7'h4E : 7'h6E;
      8'h87: c = sh ? 7'h4D : 7'h6D;
      8'h88: c = sh ? 7'h3C : 7'h2C;
      8'h89: c = sh ? 7'h3E : 7'h2E;
      8'h8A: c = sh ? 7'h3F : 7'h2F;
      8'h8D: c = 7'h31;
      8'h8E: c = 7'h32;
      8'h8F: c = 7'h33;
      8'hA2: c = 7'h20;
      8'hA8: c = 7'h30;
      8'hA9: c = 7'h2E;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/ps2s1_front.sv =====
// ps2s1_front: byte front end. Tracks the E0 prefix and swallow count,
// reads the keymap ROM (registered) and hands a command to the next stage.
// Depends on ps2s1_pkg.

module ps2s1_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       scan_byte,
  output ps2s1_pkg::s1_t   s1,
  output logic [7:0]       s1_key,
  input  logic             s1_ready
);

  logic                  phase_e0;
  logic [2:0]            skip;
  logic                  phase_e0_next;
  logic [2:0]            skip_next;
  ps2s1_pkg::cmd_t       cmd_next;
  logic [7:0]            rom_addr;
  logic                  accept;
  logic                  load;

  assign load     = !s1.valid || s1_ready;
  assign in_stall = !load;
  assign accept   = in_valid && load;
  assign rom_addr = {phase_e0, scan_byte[6:0]};

  // Per-byte decode of prefixes, swallowed sequences and break codes
  always_comb begin
    phase_e0_next = 1'b0;
    skip_next     = skip;
    cmd_next      = ps2s1_pkg::CMD_NONE;
    if (skip != 3'd0) begin
      skip_next     = skip - 3'd1;
      phase_e0_next = phase_e0;
    end else if (phase_e0) begin
      if (scan_byte == ps2s1_pkg::SC_PRTSC_A || scan_byte == ps2s1_pkg::SC_PRTSC_B) begin
        skip_next = ps2s1_pkg::SKIP_PRTSC;
      end else if (scan_byte == ps2s1_pkg::SC_CTRL_BRK) begin
        cmd_next = ps2s1_pkg::CMD_CLR_CTRL;
      end else if (scan_byte == ps2s1_pkg::SC_ALT_BRK) begin
        cmd_next = ps2s1_pkg::CMD_CLR_ALT;
      end else if (!scan_byte[7]) begin
        cmd_next = ps2s1_pkg::CMD_KEY;
      end
    end else begin
      if (scan_byte == ps2s1_pkg::SC_E0) begin
        phase_e0_next = 1'b1;
      end else if (scan_byte == ps2s1_pkg::SC_E1) begin
        skip_next = ps2s1_pkg::SKIP_PAUSE;
      end else if (scan_byte == ps2s1_pkg::SC_CTRL_BRK) begin
        cmd_next = ps2s1_pkg::CMD_CLR_CTRL;
      end else if (scan_byte == ps2s1_pkg::SC_ALT_BRK) begin
        cmd_next = ps2s1_pkg::CMD_CLR_ALT;
      end else if (scan_byte == ps2s1_pkg::SC_RSHIFT_BRK ||
                   scan_byte == ps2s1_pkg::SC_LSHIFT_BRK) begin
        cmd_next = ps2s1_pkg::CMD_CLR_SHIFT;
      end else if (!scan_byte[7]) begin
        cmd_next = ps2s1_pkg::CMD_KEY;
      end
    end
  end

  // Prefix state and stage-1 control
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_e0 <= 1'b0;
      skip     <= 3'd0;
      s1.valid <= 1'b0;
      s1.cmd   <= ps2s1_pkg::CMD_NONE;
    end else begin
      if (accept) begin
        phase_e0 <= phase_e0_next;
        skip     <= skip_next;
      end
      if (load) begin
        s1.valid <= accept && (cmd_next != ps2s1_pkg::CMD_NONE);
        s1.cmd   <= cmd_next;
      end
    end
  end

  // Keymap ROM, synchronous read
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_key <= ps2s1_pkg::key_map(rom_addr);
    end
  end

endmodule

// ===== rtl/core/ps2s1_mod.sv =====
// ps2s1_mod: modifier register update, ASCII ROM read and output register.
// Depends on ps2s1_pkg.

module ps2s1_mod (
  input  logic             clk,
  input  logic             rst,
  input  ps2s1_pkg::s1_t   s1,
  input  logic [7:0]       s1_key,
  output logic             s1_ready,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       key_code,
  output logic [5:0]       modifier_flags,
  output logic [6:0]       ascii_char
);

  logic [5:0] mods;
  logic [5:0] mods_next;
  logic       emit;
  logic       take;

  assign s1_ready = !out_valid || !out_stall;
  assign take     = s1.valid && s1_ready;

  // Modifier update; non-modifier keys inside the table produce a beat
  always_comb begin
    mods_next = mods;
    emit      = 1'b0;
    unique case (s1.cmd)
      ps2s1_pkg::CMD_CLR_SHIFT: mods_next[ps2s1_pkg::MB_SHIFT] = 1'b0;
      ps2s1_pkg::CMD_CLR_ALT:   mods_next[ps2s1_pkg::MB_ALT]   = 1'b0;
      ps2s1_pkg::CMD_CLR_CTRL:  mods_next[ps2s1_pkg::MB_CTRL]  = 1'b0;
      ps2s1_pkg::CMD_KEY: begin
        unique case (s1_key) inside
          ps2s1_pkg::KC_CAPS:
            mods_next[ps2s1_pkg::MB_CAPS] = !mods[ps2s1_pkg::MB_CAPS];
          ps2s1_pkg::KC_LSHIFT, ps2s1_pkg::KC_RSHIFT:
            mods_next[ps2s1_pkg::MB_SHIFT] = 1'b1;
          ps2s1_pkg::KC_LCTRL, ps2s1_pkg::KC_RCTRL:
            mods_next[ps2s1_pkg::MB_CTRL] = 1'b1;
          ps2s1_pkg::KC_LALT, ps2s1_pkg::KC_RALT:
            mods_next[ps2s1_pkg::MB_ALT] = 1'b1;
          ps2s1_pkg::KC_SCROLL:
            mods_next[ps2s1_pkg::MB_SCROLL] = !mods[ps2s1_pkg::MB_SCROLL];
          ps2s1_pkg::KC_NUM:
            mods_next[ps2s1_pkg::MB_NUM] = !mods[ps2s1_pkg::MB_NUM];
          default: emit = (s1_key < ps2s1_pkg::KC_LIMIT);
        endcase
      end
      default: ;
    endcase
  end

  // Control: modifier bits and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      mods      <= 6'd0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        mods <= mods_next;
      end
      if (s1_ready) begin
        out_valid <= s1.valid && emit;
      end
    end
  end

  // Output payload; ASCII ROM read registered here
  always_ff @(posedge clk) begin
    if (take && emit) begin
      key_code       <= s1_key;
      modifier_flags <= mods;
      ascii_char     <= ps2s1_pkg::ascii_map(mods[ps2s1_pkg::MB_SHIFT], s1_key);
    end
  end

endmodule

// ===== rtl/core/ps2_set1_scancode_decoder.sv =====
// ps2_set1_scancode_decoder: top level of the PS/2 set-1 scan code decoder.
// Depends on ps2s1_pkg, ps2s1_front and ps2s1_mod.

// Takes one set-1 scan code byte per beat and, for each make code of a
// non-modifier key, gives one beat carrying the row/column keycode, the six
// modifier bits and an ASCII character (0 when the key prints nothing).
// Break codes, modifier keys, unmapped codes and the whole Print Screen and
// Pause sequences give no beat. A new byte is taken every cycle unless
// in_stall is high; a result is registered first after the keymap ROM read,
// then after the modifier update and ASCII ROM read. While a result is
// held by out_stall, bytes that carry no work for the middle stage are still
// taken; in_stall rises once a byte with work sits in the middle stage, and
// drops again in the cycle the held result is taken.

module ps2_set1_scancode_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] scan_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] key_code,
  output logic [5:0] modifier_flags,
  output logic [6:0] ascii_char
);

  ps2s1_pkg::s1_t s1;
  logic [7:0]     s1_key;
  logic           s1_ready;

  ps2s1_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .scan_byte (scan_byte),
    .s1        (s1),
    .s1_key    (s1_key),
    .s1_ready  (s1_ready)
  );

  ps2s1_mod u_mod (
    .clk            (clk),
    .rst            (rst),
    .s1             (s1),
    .s1_key         (s1_key),
    .s1_ready       (s1_ready),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .key_code       (key_code),
    .modifier_flags (modifier_flags),
    .ascii_char     (ascii_char)
  );

endmodule

// ===== rtl/core/ps2s1_checker.sv =====
// ps2s1_checker: port-level assertions for the scan code decoder, bound to
// the top level. Depends on ps2_set1_scancode_decoder ports only.

module ps2s1_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] scan_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] key_code,
  input logic [5:0] modifier_flags,
  input logic [6:0] ascii_char
);

  // Input only backs up when a result is held downstream
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a held result");

  // Held result beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(key_code) &&
      $stable(modifier_flags) && $stable(ascii_char))
    else $error("held result changed");

  // Keycodes stay inside the table
  a_key_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (key_code < 8'd176))
    else $error("keycode out of range");

  // Upper-case letters only with shift
  a_shift_case: assert property (@(posedge clk) disable iff (rst)
    out_valid && !modifier_flags[0] |-> !(ascii_char >= 7'h41 && ascii_char <= 7'h5A))
    else $error("upper-case letter without shift");

  // Reset leaves no result pending
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind ps2_set1_scancode_decoder ps2s1_checker u_ps2s1_checker (.*);
